/* rtl/wma_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wma_pkg
// Shared widths, types and helpers of the windowed moving average unit.
// ----------------------------------------------------------------------------
package wma_pkg;

    localparam int DATA_W           = 32;
    localparam int CNT_W            = 7;
    localparam int SUM_W            = DATA_W + CNT_W;
    localparam int WMA_WINDOW_MAX_DEF = 64;
    localparam int WIN_RESET        = 64;

    typedef struct packed {
        logic start;
        logic negate;
    } div_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    function automatic logic [CNT_W-1:0] eff_window(input logic [CNT_W-1:0] ws,
                                                    input int wmax);
        logic [CNT_W-1:0] w;
        w = ws;
        if (w == '0) begin
            w = CNT_W'(1);
        end
        if (32'(w) > wmax) begin
            w = CNT_W'(wmax);
        end
        return w;
    endfunction

endpackage

/* rtl/windowed_moving_average_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_moving_average_unit
// Simple moving average of signed 32-bit samples over a programmable window.
// ----------------------------------------------------------------------------
// Each accepted sample enters a ring memory, updates a full-width running sum
// and yields one item: the sum of the held samples divided by their count,
// truncated toward zero, together with that count. Each item passes, in order,
// through the ring read, the sum update and ring write, the divider load, the
// bit-serial division, the check for its end and the output register load;
// no new sample is taken until that load. A result waiting on m_tready does
// not block the next sample until its own division is finished. window_size
// is accepted only between items and wins over a sample offered in the same
// cycle. Writing it clears the count, pointer and sum at once; no memory
// sweep runs.
// ----------------------------------------------------------------------------
module windowed_moving_average_unit
    import wma_pkg::*;
#(
    parameter int WINDOW_MAX = WMA_WINDOW_MAX_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [31:0]      s_tdata,    // [31:0] sample
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [39:0]      m_tdata,    // [31:0] average, [38:32] held_count
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CNT_W-1:0] cfg_data    // window_size
);

    localparam int PTR_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPDATE,
        S_START,
        S_DIV,
        S_HOLD
    } state_t;

    state_t                   state_reg, state_next;
    logic [CNT_W-1:0]         win_reg, win_next;
    logic [PTR_W-1:0]         ptr_reg, ptr_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic signed [SUM_W-1:0]  sum_reg, sum_next;
    logic signed [DATA_W-1:0] sample_reg, sample_next;
    logic [DATA_W-1:0]        avg_reg, avg_next;
    logic [CNT_W-1:0]         hc_reg, hc_next;
    logic                     m_valid_reg, m_valid_next;

    logic                     rd_en, wr_en;
    logic [DATA_W-1:0]        old_sample;
    logic signed [SUM_W-1:0]  old_ext, new_ext;
    logic                     full;
    logic                     ptr_wrap;
    logic [SUM_W-1:0]         sum_mag;
    div_ctrl_t                div_ctrl;
    div_stat_t                div_stat;
    logic [DATA_W-1:0]        div_quotient;

    assign full     = count_reg >= win_reg;
    assign ptr_wrap = (32'(ptr_reg) + 1) >= 32'(win_reg);
    assign old_ext  = SUM_W'($signed(old_sample));
    assign new_ext  = SUM_W'(sample_reg);
    assign sum_mag  = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);

    always_comb begin
        state_next   = state_reg;
        win_next     = win_reg;
        ptr_next     = ptr_reg;
        count_next   = count_reg;
        sum_next     = sum_reg;
        sample_next  = sample_reg;
        avg_next     = avg_reg;
        hc_next      = hc_reg;
        m_valid_next = m_valid_reg;
        rd_en        = 1'b0;
        wr_en        = 1'b0;
        div_ctrl     = '0;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid && s_tready) begin
                    sample_next = $signed(s_tdata);
                    rd_en       = 1'b1;
                    state_next  = S_UPDATE;
                end
            end
            S_UPDATE: begin
                wr_en      = 1'b1;
                sum_next   = sum_reg - (full ? old_ext : '0) + new_ext;
                count_next = full ? win_reg : count_reg + 1'b1;
                ptr_next   = ptr_wrap ? '0 : ptr_reg + 1'b1;
                state_next = S_START;
            end
            S_START: begin
                div_ctrl.start  = 1'b1;
                div_ctrl.negate = sum_reg[SUM_W-1];
                state_next      = S_DIV;
            end
            S_DIV: begin
                if (div_stat.done) begin
                    state_next = S_HOLD;
                end
            end
            S_HOLD: begin
                if (!m_valid_reg || m_tready) begin
                    avg_next     = div_quotient;
                    hc_next      = count_reg;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_valid && cfg_ready) begin
            win_next   = eff_window(cfg_data, WINDOW_MAX);
            ptr_next   = '0;
            count_next = '0;
            sum_next   = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            win_reg     <= eff_window(CNT_W'(WIN_RESET), WINDOW_MAX);
            ptr_reg     <= '0;
            count_reg   <= '0;
            sum_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            win_reg     <= win_next;
            ptr_reg     <= ptr_next;
            count_reg   <= count_next;
            sum_reg     <= sum_next;
            m_valid_reg <= m_valid_next;
        end
        sample_reg <= sample_next;
        avg_reg    <= avg_next;
        hc_reg     <= hc_next;
    end

    wma_ring #(
        .DEPTH  (WINDOW_MAX),
        .ADDR_W (PTR_W)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (ptr_reg),
        .wr_data (sample_reg),
        .rd_en   (rd_en),
        .rd_addr (ptr_reg),
        .rd_data (old_sample)
    );

    wma_divider #(
        .N_W (SUM_W),
        .D_W (CNT_W)
    ) u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (div_ctrl),
        .dividend (sum_mag),
        .divisor  (count_reg),
        .stat     (div_stat),
        .quotient (div_quotient)
    );

    assign s_tready  = (state_reg == S_IDLE) && !cfg_valid;
    assign cfg_ready = (state_reg == S_IDLE);
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {1'b0, hc_reg, avg_reg};

`ifndef SYNTHESIS
    a_count_in_window: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= win_reg)
        else $error("held count exceeds window");

    a_ptr_in_window: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(ptr_reg) < 32'(win_reg))
        else $error("write pointer outside window");

    a_out_count_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (hc_reg != '0))
        else $error("result item with empty window");

    a_idle_divider: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !div_stat.busy)
        else $error("input accepted while divider busy");

    a_load_after_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV && div_stat.done) |=> (state_reg == S_HOLD))
        else $error("division result not taken");
`endif

endmodule

/* rtl/wma_ring.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wma_ring
// Sample history memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module wma_ring
    import wma_pkg::*;
#(
    parameter int DEPTH  = WMA_WINDOW_MAX_DEF,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* rtl/wma_divider.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wma_divider
// Bit-serial restoring divider: one quotient bit per cycle, sign applied last.
// ----------------------------------------------------------------------------
module wma_divider
    import wma_pkg::*;
#(
    parameter int N_W = SUM_W,
    parameter int D_W = CNT_W
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  div_ctrl_t         ctrl,
    input  logic [N_W-1:0]    dividend,
    input  logic [D_W-1:0]    divisor,
    output div_stat_t         stat,
    output logic [DATA_W-1:0] quotient
);

    localparam int STEP_W = $clog2(N_W + 1);

    logic [N_W-1:0]    quo_reg, quo_next;
    logic [D_W-1:0]    rem_reg, rem_next;
    logic [D_W-1:0]    div_reg, div_next;
    logic              neg_reg, neg_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [D_W:0]      trial;
    logic              ge;
    logic [N_W-1:0]    quo_signed;

    assign trial = {rem_reg, quo_reg[N_W-1]};
    assign ge    = trial >= {1'b0, div_reg};

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        neg_next  = neg_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (ctrl.start) begin
            quo_next  = dividend;
            rem_next  = '0;
            div_next  = divisor;
            neg_next  = ctrl.negate;
            step_next = STEP_W'(N_W);
            busy_next = 1'b1;
            done_next = 1'b0;
        end else if (busy_reg) begin
            rem_next  = ge ? D_W'(trial - {1'b0, div_reg}) : trial[D_W-1:0];
            quo_next  = {quo_reg[N_W-2:0], ge};
            step_next = step_reg - 1'b1;
            if (step_reg == STEP_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
        neg_reg <= neg_next;
    end

    assign quo_signed = neg_reg ? (~quo_reg + 1'b1) : quo_reg;
    assign quotient   = quo_signed[DATA_W-1:0];
    assign stat.busy  = busy_reg;
    assign stat.done  = done_reg;

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the windowed moving average unit.
// ----------------------------------------------------------------------------
// A short table of directed samples and window writes comes first: extremes of
// the sample, windows of zero, one, two, 64 and above 64, truncation toward
// zero on negative sums. A dozen random phases follow, each after a window
// write, with random samples, runs of extreme samples and mixed idling on both
// streams. Results are checked against table values or a running-sum predictor.
// ----------------------------------------------------------------------------
module tb
    import wma_pkg::*;
();

    localparam int RING_DEPTH   = 64;
    localparam int PHASES       = 12;
    localparam int PHASE_ITEMS  = 96;
    localparam int SETTLE       = 64;
    localparam int TAB_ROWS     = 25;

    localparam logic [6:0] WINDOW_ZERO = 7'd0;
    localparam logic [6:0] WINDOW_ONE  = 7'd1;
    localparam logic [6:0] WINDOW_TWO  = 7'd2;
    localparam logic [6:0] WINDOW_FULL = 7'd64;
    localparam logic [6:0] WINDOW_OVER = 7'd65;
    localparam logic [6:0] WINDOW_TOP  = 7'd127;

    localparam logic [31:0] SMP_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] SMP_MIN = 32'h8000_0000;

    typedef enum logic {
        ROW_SAMPLE,
        ROW_WINDOW
    } row_kind_t;

    typedef struct packed {
        logic [31:0] avg;
        logic [6:0]  cnt;
    } avg_item_t;

    typedef struct packed {
        row_kind_t   kind;
        logic        typed;
        logic [31:0] value;
        logic [31:0] avg;
        logic [6:0]  cnt;
    } stim_row_t;

    typedef struct packed {
        logic      typed;
        avg_item_t val;
    } table_exp_t;

    logic             aclk      = 1'b0;
    logic             aresetn   = 1'b0;
    logic             s_tvalid  = 1'b0;
    logic             s_tready;
    logic [31:0]      s_tdata   = '0;
    logic             m_tvalid;
    logic             m_tready  = 1'b0;
    logic [39:0]      m_tdata;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [CNT_W-1:0] cfg_data  = '0;

    int send_idle  = 0;
    int recv_stall = 0;
    int errors     = 0;

    avg_item_t  pending_avg [$];
    table_exp_t table_expect [$];
    stim_row_t  stim_tab [TAB_ROWS];

    logic [6:0]         avg_window = WINDOW_FULL;
    logic signed [31:0] ring_mem [RING_DEPTH];
    logic [5:0]         ring_wr   = '0;
    logic [6:0]         ring_fill = '0;
    longint             ring_sum  = 0;

    windowed_moving_average_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int span_of(input logic [6:0] ws);
        if (ws == WINDOW_ZERO) begin
            return 1;
        end
        if (int'(ws) > RING_DEPTH) begin
            return RING_DEPTH;
        end
        return int'(ws);
    endfunction

    task automatic set_window_model(input logic [6:0] ws);
        avg_window = ws;
        ring_wr    = '0;
        ring_fill  = '0;
        ring_sum   = 0;
    endtask

    task automatic advance_average(input logic [31:0] smp, output avg_item_t res);
        int     span;
        int     wr;
        longint q;
        span = span_of(avg_window);
        wr   = int'(ring_wr);
        if (wr >= span) begin
            wr = 0;
        end
        if (int'(ring_fill) >= span) begin
            ring_sum  = ring_sum - longint'(ring_mem[wr]);
            ring_fill = 7'(span);
        end else begin
            ring_fill = ring_fill + 7'd1;
        end
        ring_mem[wr] = $signed(smp);
        ring_sum     = ring_sum + longint'($signed(smp));
        wr = wr + 1;
        if (wr >= span) begin
            wr = 0;
        end
        ring_wr = 6'(wr);
        q       = ring_sum / longint'(ring_fill);
        res.avg = q[31:0];
        res.cnt = ring_fill;
    endtask

    always @(posedge aclk) begin : monitor
        avg_item_t  pred;
        avg_item_t  want;
        table_exp_t te;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                set_window_model(cfg_data);
            end
            if (s_tvalid && s_tready) begin
                advance_average(s_tdata, pred);
                if (table_expect.size() != 0) begin
                    te = table_expect[0];
                    table_expect.delete(0);
                    if (te.typed) begin
                        pred = te.val;
                    end
                end
                pending_avg.insert(pending_avg.size(), pred);
            end
            if (m_tvalid && m_tready) begin
                if (pending_avg.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected item avg=%h cnt=%0d", $time,
                             m_tdata[31:0], m_tdata[38:32]);
                end else begin
                    want = pending_avg[0];
                    pending_avg.delete(0);
                    if (m_tdata[31:0] !== want.avg) begin
                        errors++;
                        $display("%0t: average expected %h actual %h", $time,
                                 want.avg, m_tdata[31:0]);
                    end
                    if (m_tdata[38:32] !== want.cnt) begin
                        errors++;
                        $display("%0t: held_count expected %0d actual %0d", $time,
                                 want.cnt, m_tdata[38:32]);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall);
    end

    task automatic set_idle(input int mode);
        case (mode)
            0: begin
                send_idle  = 0;
                recv_stall = 0;
            end
            1: begin
                send_idle  = 65;
                recv_stall = 0;
            end
            2: begin
                send_idle  = 0;
                recv_stall = 65;
            end
            default: begin
                send_idle  = 26;
                recv_stall = 26;
            end
        endcase
    endtask

    task automatic send_sample(input logic [31:0] smp);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_avg.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic write_window(input logic [6:0] ws);
        cfg_valid <= 1'b1;
        cfg_data  <= ws;
        @(posedge aclk);
        while (!cfg_ready) begin
            @(posedge aclk);
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] pick_sample(input bit extremes);
        int r;
        r = $urandom_range(9);
        if (extremes || r < 2) begin
            return $urandom_range(1) ? SMP_MAX : SMP_MIN;
        end
        if (r < 4) begin
            return 32'($urandom_range(31)) - 32'd16;
        end
        return $urandom();
    endfunction

    initial begin
        int          p;
        int          i;
        logic [6:0]  ws;
        table_exp_t  te;
        stim_tab = '{
            '{ROW_SAMPLE, 1'b1, 32'h0000_0000, 32'h0000_0000, 7'd1},
            '{ROW_SAMPLE, 1'b1, SMP_MAX,       32'h3FFF_FFFF, 7'd2},
            '{ROW_WINDOW, 1'b0, 32'(WINDOW_ONE),  32'h0, 7'd0},
            '{ROW_SAMPLE, 1'b1, SMP_MIN,       SMP_MIN,       7'd1},
            '{ROW_SAMPLE, 1'b1, SMP_MAX,       SMP_MAX,       7'd1},
            '{ROW_SAMPLE, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 7'd1},
            '{ROW_WINDOW, 1'b0, 32'(WINDOW_ZERO), 32'h0, 7'd0},
            '{ROW_SAMPLE, 1'b1, 32'h0000_0005, 32'h0000_0005, 7'd1},
            '{ROW_SAMPLE, 1'b1, 32'hFFFF_FFF9, 32'hFFFF_FFF9, 7'd1},
            '{ROW_WINDOW, 1'b0, 32'(WINDOW_TWO),  32'h0, 7'd0},
            '{ROW_SAMPLE, 1'b1, 32'hFFFF_FFFD, 32'hFFFF_FFFD, 7'd1},
            '{ROW_SAMPLE, 1'b1, 32'h0000_0000, 32'hFFFF_FFFF, 7'd2},
            '{ROW_SAMPLE, 1'b1, 32'h0000_0004, 32'h0000_0002, 7'd2},
            '{ROW_WINDOW, 1'b0, 32'(WINDOW_TOP),  32'h0, 7'd0},
            '{ROW_SAMPLE, 1'b1, SMP_MIN,       SMP_MIN,       7'd1},
            '{ROW_SAMPLE, 1'b1, SMP_MIN,       SMP_MIN,       7'd2},
            '{ROW_SAMPLE, 1'b1, SMP_MIN,       SMP_MIN,       7'd3},
            '{ROW_WINDOW, 1'b0, 32'(WINDOW_OVER), 32'h0, 7'd0},
            '{ROW_SAMPLE, 1'b1, SMP_MAX,       SMP_MAX,       7'd1},
            '{ROW_SAMPLE, 1'b1, SMP_MAX,       SMP_MAX,       7'd2},
            '{ROW_WINDOW, 1'b0, 32'd3,         32'h0, 7'd0},
            '{ROW_SAMPLE, 1'b0, 32'h5555_5555, 32'h0, 7'd0},
            '{ROW_SAMPLE, 1'b0, 32'hAAAA_AAAA, 32'h0, 7'd0},
            '{ROW_SAMPLE, 1'b0, 32'h0000_0001, 32'h0, 7'd0},
            '{ROW_SAMPLE, 1'b0, 32'h8000_0001, 32'h0, 7'd0}
        };

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        set_idle(0);
        for (i = 0; i < TAB_ROWS; i++) begin
            if (stim_tab[i].kind == ROW_WINDOW) begin
                wait_idle();
                write_window(stim_tab[i].value[6:0]);
            end else begin
                te.typed   = stim_tab[i].typed;
                te.val.avg = stim_tab[i].avg;
                te.val.cnt = stim_tab[i].cnt;
                table_expect.insert(table_expect.size(), te);
                send_sample(stim_tab[i].value);
            end
        end

        for (p = 0; p < PHASES; p++) begin
            case (p)
                0: ws = WINDOW_FULL;
                1: ws = WINDOW_ONE;
                2: ws = WINDOW_ZERO;
                3: ws = WINDOW_TOP;
                4: ws = WINDOW_TWO;
                5: ws = WINDOW_FULL;
                6: ws = WINDOW_OVER;
                default: ws = ($urandom_range(3) == 0) ? 7'($urandom_range(127))
                                                       : 7'($urandom_range(64, 1));
            endcase
            wait_idle();
            write_window(ws);
            set_idle(p % 4);
            for (i = 0; i < PHASE_ITEMS; i++) begin
                send_sample(pick_sample(p == 5));
            end
        end

        wait_idle();
        repeat (SETTLE) @(posedge aclk);
        if (errors == 0 && pending_avg.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #(5_000_000);
        $display("FAIL");
        $finish;
    end

endmodule
